// ----- rtl/sctnl_pkg.sv -----
package sctnl_pkg;

    // default sizes
    localparam int DEF_NUM_ROWS   = 256;
    localparam int DEF_MAX_TOPICS = 64;
    localparam int DEF_COUNT_BITS = 32;

    // port field widths
    localparam int ROW_W      = 8;
    localparam int TOPIC_W    = 7;
    localparam int DELTA_W    = 16;
    localparam int CNT_W      = 32;
    localparam int CHG_W      = 2;
    localparam int ST_W       = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;

    // topics_in_use after reset
    localparam logic [TOPIC_W-1:0] TOPICS_RESET = 7'd64;

    // opcodes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // list change codes
    localparam logic [CHG_W-1:0] CHG_NONE   = 2'd0;
    localparam logic [CHG_W-1:0] CHG_INSERT = 2'd1;
    localparam logic [CHG_W-1:0] CHG_UNLINK = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE      = 2'd1;
    localparam logic [ST_W-1:0] ST_CLAMP_ZERO = 2'd2;
    localparam logic [ST_W-1:0] ST_SAT_MAX    = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_LINK,
        S_PATCH
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic calc;
        logic link_wr;
        logic patch_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/sctnl_ctrl.sv -----
module sctnl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  sctnl_pkg::t_stat  i_stat,
    output logic              o_s_tready,
    output sctnl_pkg::t_cmd   o_cmd
);

    sctnl_pkg::t_state r_state;
    sctnl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sctnl_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sctnl_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = sctnl_pkg::S_IDLE;
            end
            sctnl_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = sctnl_pkg::S_CALC;
            end
            sctnl_pkg::S_CALC: begin
                n_state = sctnl_pkg::S_LINK;
            end
            sctnl_pkg::S_LINK: begin
                n_state = sctnl_pkg::S_PATCH;
            end
            sctnl_pkg::S_PATCH: begin
                if (i_stat.out_free) n_state = sctnl_pkg::S_IDLE;
            end
            default: begin
                n_state = sctnl_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            sctnl_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            sctnl_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            sctnl_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
            end
            sctnl_pkg::S_LINK: begin
                o_cmd.link_wr = 1'b1;
            end
            sctnl_pkg::S_PATCH: begin
                // neighbor patches are idempotent, so they repeat while the
                // output register is still occupied
                o_cmd.patch_wr = 1'b1;
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // the clearing pass runs once, after reset only
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != sctnl_pkg::S_CLEAR) |=> (r_state != sctnl_pkg::S_CLEAR))
        else $error("clearing pass re-entered");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_state == sctnl_pkg::S_IDLE))
        else $error("input ready outside idle");

    a_load_patch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (r_state == sctnl_pkg::S_PATCH))
        else $error("result loaded outside patch step");

endmodule

// ----- rtl/sctnl_dp.sv -----
module sctnl_dp #(
    parameter int NUM_ROWS   = sctnl_pkg::DEF_NUM_ROWS,
    parameter int MAX_TOPICS = sctnl_pkg::DEF_MAX_TOPICS,
    parameter int COUNT_BITS = sctnl_pkg::DEF_COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sctnl_pkg::t_cmd                   i_cmd,
    output sctnl_pkg::t_stat                  o_stat,
    input  logic                              i_opcode,
    input  logic [sctnl_pkg::ROW_W-1:0]       i_row,
    input  logic [sctnl_pkg::TOPIC_W-1:0]     i_topic,
    input  logic signed [sctnl_pkg::DELTA_W-1:0] i_delta,
    input  logic [sctnl_pkg::TOPIC_W-1:0]     i_topics_cfg,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [sctnl_pkg::CNT_W-1:0]       o_old_count,
    output logic [sctnl_pkg::CNT_W-1:0]       o_new_count,
    output logic [sctnl_pkg::TOPIC_W-1:0]     o_head_topic,
    output logic [sctnl_pkg::CHG_W-1:0]       o_list_change,
    output logic [sctnl_pkg::ST_W-1:0]        o_status
);

    localparam int SLOTS  = MAX_TOPICS + 1;
    localparam int DEPTH  = NUM_ROWS * SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int LINK_W = $clog2(MAX_TOPICS + 1);
    localparam int TW     = (LINK_W > sctnl_pkg::TOPIC_W) ? LINK_W : sctnl_pkg::TOPIC_W;
    localparam int SUM_W  = ((COUNT_BITS > sctnl_pkg::DELTA_W) ? COUNT_BITS
                                                               : sctnl_pkg::DELTA_W) + 2;
    localparam logic [LINK_W-1:0]     NONE    = LINK_W'(MAX_TOPICS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // storage
    logic [COUNT_BITS-1:0] r_cnt_mem  [DEPTH];
    logic [LINK_W-1:0]     r_prev_mem [DEPTH];
    logic [LINK_W-1:0]     r_next_mem [DEPTH];
    logic [LINK_W-1:0]     r_head_mem [NUM_ROWS];

    logic [ADDR_W-1:0] r_clr_idx;

    // accept side
    logic [TW-1:0]     w_cfg_ext;
    logic [TW-1:0]     w_ntop;
    logic [TW-1:0]     w_topic_ext;
    logic              w_row_ok;
    logic              w_topic_ok;
    logic              w_is_list;
    logic [ROW_AW-1:0] w_row_idx;
    logic [ADDR_W-1:0] w_base;
    logic [ADDR_W-1:0] w_slot;
    logic              w_rd_en;

    logic                               r_op;
    logic [LINK_W-1:0]                  r_topic;
    logic signed [sctnl_pkg::DELTA_W-1:0] r_delta;
    logic [ROW_AW-1:0]                  r_row_idx;
    logic [ADDR_W-1:0]                  r_base;
    logic [ADDR_W-1:0]                  r_slot;
    logic                               r_row_ok;
    logic                               r_topic_ok;
    logic                               r_is_list;

    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [LINK_W-1:0]     r_prev_rd;
    logic [LINK_W-1:0]     r_next_rd;
    logic [LINK_W-1:0]     r_head_rd;

    // update stage
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_neg;
    logic                    w_over;
    logic [COUNT_BITS-1:0]   w_new;
    logic                    w_add;
    logic                    w_linked;
    logic                    w_old_zero;
    logic                    w_new_zero;

    logic [COUNT_BITS-1:0]      r_new;
    logic                       r_wr_cnt;
    logic                       r_ins;
    logic                       r_unl;
    logic [sctnl_pkg::ST_W-1:0] r_status;

    // neighbor patch
    logic              r_pp_en;
    logic [ADDR_W-1:0] r_pp_addr;
    logic [LINK_W-1:0] r_pp_data;
    logic              r_np_en;
    logic [ADDR_W-1:0] r_np_addr;
    logic [LINK_W-1:0] r_np_data;

    // write ports
    logic                  w_cnt_we;
    logic [ADDR_W-1:0]     w_cnt_wa;
    logic [COUNT_BITS-1:0] w_cnt_wd;
    logic                  w_prev_we;
    logic [ADDR_W-1:0]     w_prev_wa;
    logic [LINK_W-1:0]     w_prev_wd;
    logic                  w_next_we;
    logic [ADDR_W-1:0]     w_next_wa;
    logic [LINK_W-1:0]     w_next_wd;
    logic                  w_head_we;
    logic [ROW_AW-1:0]     w_head_wa;
    logic [LINK_W-1:0]     w_head_wd;

    // output register
    logic                        r_out_valid;
    logic [COUNT_BITS-1:0]       r_out_old;
    logic [COUNT_BITS-1:0]       r_out_new;
    logic [LINK_W-1:0]           r_out_head;
    logic [sctnl_pkg::CHG_W-1:0] r_out_change;
    logic [sctnl_pkg::ST_W-1:0]  r_out_status;
    logic                        w_ok;

    //------------------------------------------------------------------
    // address and range checks on the incoming item
    assign w_cfg_ext   = TW'(i_topics_cfg);
    assign w_ntop      = (w_cfg_ext > TW'(MAX_TOPICS)) ? TW'(MAX_TOPICS) : w_cfg_ext;
    assign w_topic_ext = TW'(i_topic);
    assign w_row_ok    = (32'(i_row) < 32'(NUM_ROWS));
    assign w_topic_ok  = (w_topic_ext <= w_ntop);
    assign w_is_list   = (w_topic_ext < w_ntop);
    assign w_row_idx   = ROW_AW'(i_row);
    assign w_base      = ADDR_W'(w_row_idx) * ADDR_W'(SLOTS);
    assign w_slot      = w_base + ADDR_W'(w_topic_ext);
    assign w_rd_en     = i_cmd.accept && w_row_ok && w_topic_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_opcode;
            r_topic    <= LINK_W'(i_topic);
            r_delta    <= i_delta;
            r_row_idx  <= w_row_idx;
            r_base     <= w_base;
            r_slot     <= w_slot;
            r_row_ok   <= w_row_ok;
            r_topic_ok <= w_topic_ok;
            r_is_list  <= w_is_list;
        end
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_cnt_rd  <= r_cnt_mem[w_slot];
            r_prev_rd <= r_prev_mem[w_slot];
            r_next_rd <= r_next_mem[w_slot];
        end
        if (i_cmd.accept && w_row_ok) begin
            r_head_rd <= r_head_mem[w_row_idx];
        end
    end

    //------------------------------------------------------------------
    // saturating update and list decision
    assign w_sum      = $signed(SUM_W'(r_cnt_rd)) + SUM_W'(r_delta);
    assign w_neg      = w_sum[SUM_W-1];
    assign w_over     = !w_neg && (w_sum > $signed(SUM_W'(CNT_MAX)));
    assign w_new      = w_neg ? '0 : (w_over ? CNT_MAX : w_sum[COUNT_BITS-1:0]);
    assign w_add      = (r_op == sctnl_pkg::OP_ADD) && r_row_ok && r_topic_ok;
    assign w_linked   = (r_head_rd == r_topic) || (r_prev_rd != NONE);
    assign w_old_zero = (r_cnt_rd == '0);
    assign w_new_zero = (w_new == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins <= 1'b0;
            r_unl <= 1'b0;
        end else if (i_cmd.calc) begin
            r_ins <= w_add && r_is_list && w_old_zero && !w_new_zero && !w_linked;
            r_unl <= w_add && r_is_list && !w_old_zero && w_new_zero && w_linked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_new    <= w_add ? w_new : r_cnt_rd;
            r_wr_cnt <= w_add;
            if (!(r_row_ok && r_topic_ok)) begin
                r_status <= sctnl_pkg::ST_RANGE;
            end else if (r_op == sctnl_pkg::OP_READ) begin
                r_status <= sctnl_pkg::ST_OK;
            end else if (w_neg) begin
                r_status <= sctnl_pkg::ST_CLAMP_ZERO;
            end else if (w_over) begin
                r_status <= sctnl_pkg::ST_SAT_MAX;
            end else begin
                r_status <= sctnl_pkg::ST_OK;
            end
        end
    end

    // neighbor addresses, used in the next cycle by the patch step
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_wr) begin
            r_pp_en   <= (r_ins && (r_head_rd != NONE)) || (r_unl && (r_next_rd != NONE));
            r_pp_addr <= r_base + ADDR_W'(r_ins ? r_head_rd : r_next_rd);
            r_pp_data <= r_ins ? r_topic : r_prev_rd;
            r_np_en   <= r_unl && (r_prev_rd != NONE);
            r_np_addr <= r_base + ADDR_W'(r_prev_rd);
            r_np_data <= r_next_rd;
        end
    end

    //------------------------------------------------------------------
    // write port selection: clearing pass, own slot, neighbor patch
    always_comb begin
        w_cnt_we  = 1'b0;
        w_cnt_wa  = r_slot;
        w_cnt_wd  = r_new;
        w_prev_we = 1'b0;
        w_prev_wa = r_slot;
        w_prev_wd = NONE;
        w_next_we = 1'b0;
        w_next_wa = r_slot;
        w_next_wd = NONE;
        w_head_we = 1'b0;
        w_head_wa = r_row_idx;
        w_head_wd = r_ins ? r_topic : r_next_rd;
        if (i_cmd.clr_step) begin
            w_cnt_we  = 1'b1;
            w_cnt_wa  = r_clr_idx;
            w_cnt_wd  = '0;
            w_prev_we = 1'b1;
            w_prev_wa = r_clr_idx;
            w_next_we = 1'b1;
            w_next_wa = r_clr_idx;
            w_head_we = (r_clr_idx < ADDR_W'(NUM_ROWS));
            w_head_wa = ROW_AW'(r_clr_idx);
            w_head_wd = NONE;
        end else if (i_cmd.link_wr) begin
            w_cnt_we  = r_wr_cnt;
            w_prev_we = r_ins || r_unl;
            w_next_we = r_ins || r_unl;
            w_next_wd = r_ins ? r_head_rd : NONE;
            w_head_we = r_ins || (r_unl && (r_prev_rd == NONE));
        end else if (i_cmd.patch_wr) begin
            w_prev_we = r_pp_en;
            w_prev_wa = r_pp_addr;
            w_prev_wd = r_pp_data;
            w_next_we = r_np_en;
            w_next_wa = r_np_addr;
            w_next_wd = r_np_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) r_cnt_mem[w_cnt_wa] <= w_cnt_wd;
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) r_prev_mem[w_prev_wa] <= w_prev_wd;
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) r_next_mem[w_next_wa] <= w_next_wd;
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) r_head_mem[w_head_wa] <= w_head_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_idx <= r_clr_idx + ADDR_W'(1);
        end
    end

    //------------------------------------------------------------------
    // result register
    assign w_ok = r_row_ok && r_topic_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_old    <= w_ok ? r_cnt_rd : '0;
            r_out_new    <= w_ok ? r_new : '0;
            r_out_status <= r_status;
            if (!r_row_ok) begin
                r_out_head <= NONE;
            end else if (r_ins) begin
                r_out_head <= r_topic;
            end else if (r_unl && (r_prev_rd == NONE)) begin
                r_out_head <= r_next_rd;
            end else begin
                r_out_head <= r_head_rd;
            end
            if (r_ins) begin
                r_out_change <= sctnl_pkg::CHG_INSERT;
            end else if (r_unl) begin
                r_out_change <= sctnl_pkg::CHG_UNLINK;
            end else begin
                r_out_change <= sctnl_pkg::CHG_NONE;
            end
        end
    end

    assign o_stat.clr_last = (r_clr_idx == ADDR_W'(DEPTH - 1));
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid    = r_out_valid;
    assign o_old_count   = sctnl_pkg::CNT_W'(r_out_old);
    assign o_new_count   = sctnl_pkg::CNT_W'(r_out_new);
    assign o_head_topic  = sctnl_pkg::TOPIC_W'(r_out_head);
    assign o_list_change = r_out_change;
    assign o_status      = r_out_status;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a pending item");

    a_ins_unl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ins && r_unl))
        else $error("insert and unlink decided together");

    a_range_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == sctnl_pkg::ST_RANGE))
            |-> ((r_out_change == sctnl_pkg::CHG_NONE) && (r_out_new == '0)))
        else $error("out-of-range item changed state");

endmodule

// ----- rtl/sparse_count_table_nonzero_list.sv -----
// Path: the registered read at input accept, then update, link write and
//   neighbor patch before o_m_tvalid rises; the patch step waits while
//   i_m_tready holds the output register.
// Throughput: one item at a time, through four steps (accept with read,
//   update, own-slot link write, neighbor patch on the single write port).
// Reset: i_rst_n synchronous, active low. After reset a clearing pass over
//   all NUM_ROWS*(MAX_TOPICS+1) slots (16640 by default) runs with o_s_tready low.
module sparse_count_table_nonzero_list #(
    parameter int NUM_ROWS   = sctnl_pkg::DEF_NUM_ROWS,
    parameter int MAX_TOPICS = sctnl_pkg::DEF_MAX_TOPICS,
    parameter int COUNT_BITS = sctnl_pkg::DEF_COUNT_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // row[7:0], topic[14:8], delta[30:15], zero[31]
    input  logic [sctnl_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // opcode[0]
    input  logic [0:0]                          i_s_tuser,
    // result items
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // old_count[31:0], new_count[63:32], head_topic[70:64],
    // list_change[72:71], status[74:73], zero[79:75]
    output logic [sctnl_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // topics_in_use register
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sctnl_pkg::TOPIC_W-1:0]       i_cfg_data
);

    localparam int OUT_USED_W = 2 * sctnl_pkg::CNT_W + sctnl_pkg::TOPIC_W
                              + sctnl_pkg::CHG_W + sctnl_pkg::ST_W;
    localparam int OUT_PAD_W  = sctnl_pkg::OUT_DATA_W - OUT_USED_W;

    // field offsets in the input item
    localparam int TOPIC_LSB = sctnl_pkg::ROW_W;
    localparam int DELTA_LSB = TOPIC_LSB + sctnl_pkg::TOPIC_W;

    sctnl_pkg::t_cmd  w_cmd;
    sctnl_pkg::t_stat w_stat;

    logic [sctnl_pkg::TOPIC_W-1:0] r_topics_cfg;

    logic [sctnl_pkg::CNT_W-1:0]   w_old_count;
    logic [sctnl_pkg::CNT_W-1:0]   w_new_count;
    logic [sctnl_pkg::TOPIC_W-1:0] w_head_topic;
    logic [sctnl_pkg::CHG_W-1:0]   w_list_change;
    logic [sctnl_pkg::ST_W-1:0]    w_status;

    // topics_in_use: also the index of the common entry. Writes must come only
    // while the block is quiet; the block does not enforce this. The port is always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topics_cfg <= sctnl_pkg::TOPICS_RESET;
        end else if (i_cfg_valid) begin
            r_topics_cfg <= i_cfg_data;
        end
    end

    // sequencer: clear sweep, then accept / update / link / patch per item
    sctnl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // counter and link memories, saturating adder, result register
    sctnl_dp #(
        .NUM_ROWS   (NUM_ROWS),
        .MAX_TOPICS (MAX_TOPICS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_opcode      (i_s_tuser[0]),
        .i_row         (i_s_tdata[TOPIC_LSB-1:0]),
        .i_topic       (i_s_tdata[DELTA_LSB-1:TOPIC_LSB]),
        .i_delta       ($signed(i_s_tdata[DELTA_LSB+sctnl_pkg::DELTA_W-1:DELTA_LSB])),
        .i_topics_cfg  (r_topics_cfg),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_old_count   (w_old_count),
        .o_new_count   (w_new_count),
        .o_head_topic  (w_head_topic),
        .o_list_change (w_list_change),
        .o_status      (w_status)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, w_status, w_list_change, w_head_topic,
                        w_new_count, w_old_count};

endmodule
